// ===== rtl/core/cle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// shared types, widths and character codes for the console line editor
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int POS_W     = ADDR_W + 1;

  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(BUF_DEPTH);

  // character codes
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_NUL    = 8'h00;

  localparam logic [7:0] CNT_MAX = 8'hff;

  // commands
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // echo kinds
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  // read status codes
  localparam logic [2:0] RD_NONE  = 3'd0;
  localparam logic [2:0] RD_BYTE  = 3'd1;
  localparam logic [2:0] RD_EOL   = 3'd2;
  localparam logic [2:0] RD_EOF   = 3'd3;
  localparam logic [2:0] RD_EMPTY = 3'd4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_char;
    logic       read_is_first;
  } cle_in_t;

  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       show_processes;
    logic [2:0] read_status;
    logic [7:0] read_byte;
    logic       eof_consumed;
  } cle_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } cle_ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_KILL,
    ST_RD_WAIT,
    ST_HOLD
  } cle_state_t;

endpackage

// ===== rtl/core/cle_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_line_ram
// line buffer storage, one write and one registered read port
// ----------------------------------------------------------------------------
module cle_line_ram
  import cle_pkg::*;
(
  input  logic         clk,
  input  cle_ram_req_t req,
  output logic [7:0]   rdata
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cle_edit_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_edit_ctrl
// sequencer for editing, commit and read over the line buffer positions
// ----------------------------------------------------------------------------
module cle_edit_ctrl
  import cle_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_fire,
  input  cle_in_t      in_item,
  input  logic         res_take,
  input  logic [7:0]   ram_rdata,
  output cle_ram_req_t ram_req,
  output logic         idle,
  output logic         res_valid,
  output cle_out_t     res
);

  cle_state_t       state_r, state_nxt;
  cle_in_t          item_r, item_nxt;
  cle_out_t         res_r, res_nxt;
  logic [POS_W-1:0] read_r, read_nxt;
  logic [POS_W-1:0] commit_r, commit_nxt;
  logic [POS_W-1:0] edit_r, edit_nxt;
  logic [7:0]       cnt_r, cnt_nxt;

  logic [POS_W-1:0] edit_m1, edit_m2, edit_p1, room_diff, fill_diff, read_p1;
  logic [7:0]       ch, ch_mapped, cnt_inc;
  logic             has_uncommitted, has_committed, kill_start, kill_done;

  assign ch              = item_r.rx_char;
  assign ch_mapped       = (ch == KEY_CR) ? KEY_LF : ch;
  assign edit_m1         = edit_r - POS_ONE;
  assign edit_m2         = edit_r - POS_W'(2);
  assign edit_p1         = edit_r + POS_ONE;
  assign read_p1         = read_r + POS_ONE;
  assign room_diff       = edit_r - read_r;
  assign fill_diff       = edit_p1 - read_r;
  assign cnt_inc         = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 8'd1;
  assign has_uncommitted = (edit_r != commit_r);
  assign has_committed   = (read_r != commit_r);
  assign kill_start      = (item_r.cmd == CMD_RX) && (ch == KEY_CTRL_U) && has_uncommitted;
  // scan stops at a line feed or when the commit point is reached
  assign kill_done       = (ram_rdata == KEY_LF) || (edit_m1 == commit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      read_r   <= '0;
      commit_r <= '0;
      edit_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      read_r   <= read_nxt;
      commit_r <= commit_nxt;
      edit_r   <= edit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    cnt_r  <= cnt_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (kill_start) begin
          state_nxt = ST_KILL;
        end else if (item_r.cmd == CMD_READ && has_committed) begin
          state_nxt = ST_RD_WAIT;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_KILL: begin
        if (kill_done) state_nxt = ST_HOLD;
      end
      ST_RD_WAIT: begin
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt   = item_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    read_nxt   = read_r;
    commit_nxt = commit_r;
    edit_nxt   = edit_r;
    ram_req    = '0;
    idle       = 1'b0;
    res_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) item_nxt = in_item;
      end
      ST_EXEC: begin
        res_nxt = '0;
        cnt_nxt = '0;
        if (item_r.cmd == CMD_RX) begin
          unique case (ch) inside
            KEY_CTRL_P: begin
              res_nxt.show_processes = 1'b1;
            end
            KEY_CTRL_U: begin
              if (has_uncommitted) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = edit_m1[ADDR_W-1:0];
              end
            end
            KEY_CTRL_H, KEY_DEL: begin
              if (has_uncommitted) begin
                edit_nxt            = edit_m1;
                res_nxt.echo_kind   = ECHO_ERASE;
                res_nxt.erase_count = 8'd1;
              end
            end
            default: begin
              if (ch != KEY_NUL && !room_diff[POS_W-1]) begin
                ram_req.we        = 1'b1;
                ram_req.waddr     = edit_r[ADDR_W-1:0];
                ram_req.wdata     = ch_mapped;
                edit_nxt          = edit_p1;
                res_nxt.echo_kind = ECHO_CHAR;
                res_nxt.echo_char = ch_mapped;
                if (ch_mapped == KEY_LF || ch_mapped == KEY_CTRL_D ||
                    fill_diff == POS_FULL) begin
                  commit_nxt         = edit_p1;
                  res_nxt.line_ready = 1'b1;
                end
              end
            end
          endcase
        end else begin
          if (has_committed) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = read_r[ADDR_W-1:0];
          end else begin
            res_nxt.read_status = RD_EMPTY;
          end
        end
      end
      ST_KILL: begin
        // ram_rdata holds the byte just before edit_r
        if (ram_rdata != KEY_LF) begin
          edit_nxt = edit_m1;
          cnt_nxt  = cnt_inc;
        end
        if (kill_done) begin
          if (ram_rdata != KEY_LF) begin
            res_nxt.echo_kind   = ECHO_ERASE;
            res_nxt.erase_count = cnt_inc;
          end else if (cnt_r != 8'd0) begin
            res_nxt.echo_kind   = ECHO_ERASE;
            res_nxt.erase_count = cnt_r;
          end
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = edit_m2[ADDR_W-1:0];
        end
      end
      ST_RD_WAIT: begin
        if (ram_rdata == KEY_CTRL_D) begin
          res_nxt.read_status = RD_EOF;
          if (item_r.read_is_first) begin
            read_nxt             = read_p1;
            res_nxt.eof_consumed = 1'b1;
          end
        end else begin
          read_nxt            = read_p1;
          res_nxt.read_byte   = ram_rdata;
          res_nxt.read_status = (ram_rdata == KEY_LF) ? RD_EOL : RD_BYTE;
        end
      end
      ST_HOLD: begin
        res_valid = 1'b1;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  assign res = res_r;

  // buffer occupancy never exceeds the depth, commit lies between read and edit
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (edit_r - read_r) <= POS_FULL && (commit_r - read_r) <= (edit_r - read_r))
    else $error("line buffer positions out of order");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> state_r == ST_EXEC)
    else $error("line buffer written outside execute");

  a_kill_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_KILL |-> has_uncommitted)
    else $error("kill scan with nothing uncommitted");

  a_read_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(read_r) |-> $past(state_r) == ST_RD_WAIT)
    else $error("read position moved outside a read");

  a_commit_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(commit_r) |-> $past(state_r) == ST_EXEC)
    else $error("commit position moved outside execute");

endmodule

// ===== rtl/core/console_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor
// cooked-mode terminal line editor over a ring of BUF_DEPTH bytes
// ----------------------------------------------------------------------------
// Each input transaction is either a received character (edit, store, echo,
// commit on LF, Ctrl-D or a full buffer) or a read request that pops at most
// one committed byte; each gives exactly one result transaction. The bytes
// live in a line memory with a single registered read port, and the read,
// commit and edit positions sit in registers beside it. A plain character,
// backspace, Ctrl-P or an empty read passes through the execute and hold
// states; a read of a stored byte adds a wait state for the memory read;
// Ctrl-U adds a backward scan in the kill state, one memory read issued per
// cycle, up to a line feed or the commit point. The result sits in an
// output register, so the next transaction is accepted while it waits.
// No reset pass over the memory: an entry is read only after it was written.
// ----------------------------------------------------------------------------
module console_line_editor
  import cle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cle_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cle_out_t out_data
);

  cle_ram_req_t ram_req;
  logic [7:0]   ram_rdata;
  logic         ctrl_idle;
  logic         res_valid;
  cle_out_t     res;
  logic         res_take;
  logic         in_fire;

  logic         out_valid_r, out_valid_nxt;
  cle_out_t     out_data_r, out_data_nxt;

  // the sequencer takes a new transaction whenever it is idle
  assign in_ready = ctrl_idle;
  assign in_fire  = in_valid && in_ready;

  // output register frees when empty or being taken this cycle
  assign res_take = !out_valid_r || out_ready;

  cle_line_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  cle_edit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .res_take  (res_take),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/cle_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_result_checker
// watches both channels of the console line editor and checks every result
// ----------------------------------------------------------------------------
// Each accepted input transaction is run through a line-editing predictor.
// The predictor keeps its own copy of the ring and of the three positions.
// The expected result is queued. Each accepted result is compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module cle_result_checker
  import cle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  cle_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  cle_out_t out_data,
  output int       errors,
  output int       pending,
  output int       n_results,
  output int       n_erasures,
  output int       n_full_commits,
  output int       n_eof_reads
);

  logic [7:0]       ring [BUF_DEPTH];
  logic [POS_W-1:0] read_pos;
  logic [POS_W-1:0] commit_pos;
  logic [POS_W-1:0] edit_pos;

  cle_out_t awaited_results [$];

  assign pending = awaited_results.size();

  function automatic cle_out_t line_editor_result(cle_in_t item);
    cle_out_t         res;
    int               erased;
    logic [7:0]       ch;
    logic [7:0]       head;
    logic [POS_W-1:0] prev;
    logic [POS_W-1:0] fill;
    res    = '0;
    erased = 0;
    ch     = item.rx_char;
    if (item.cmd == CMD_RX) begin
      fill = edit_pos - read_pos;
      if (ch == KEY_CTRL_P) begin
        res.show_processes = 1'b1;
      end else if (ch == KEY_CTRL_U) begin
        // walk back over the uncommitted line, stopping at a newline
        while (edit_pos != commit_pos) begin
          prev = edit_pos - POS_ONE;
          if (ring[prev[ADDR_W-1:0]] == KEY_LF) break;
          edit_pos = prev;
          erased++;
        end
        if (erased > 0) res.echo_kind = ECHO_ERASE;
      end else if (ch == KEY_CTRL_H || ch == KEY_DEL) begin
        if (edit_pos != commit_pos) begin
          edit_pos      = edit_pos - POS_ONE;
          erased        = 1;
          res.echo_kind = ECHO_ERASE;
        end
      end else if (ch != KEY_NUL && fill < POS_FULL) begin
        if (ch == KEY_CR) ch = KEY_LF;
        res.echo_kind                = ECHO_CHAR;
        res.echo_char                = ch;
        ring[edit_pos[ADDR_W-1:0]]   = ch;
        edit_pos                     = edit_pos + POS_ONE;
        fill                         = edit_pos - read_pos;
        if (ch == KEY_LF || ch == KEY_CTRL_D || fill == POS_FULL) begin
          commit_pos     = edit_pos;
          res.line_ready = 1'b1;
        end
      end
    end else begin
      if (read_pos == commit_pos) begin
        res.read_status = RD_EMPTY;
      end else begin
        head = ring[read_pos[ADDR_W-1:0]];
        if (head == KEY_CTRL_D) begin
          // end-of-file mark only leaves the ring on the first byte of a read
          res.read_status = RD_EOF;
          if (item.read_is_first) begin
            read_pos         = read_pos + POS_ONE;
            res.eof_consumed = 1'b1;
          end
        end else begin
          read_pos        = read_pos + POS_ONE;
          res.read_byte   = head;
          res.read_status = (head == KEY_LF) ? RD_EOL : RD_BYTE;
        end
      end
    end
    res.erase_count = (erased > int'(CNT_MAX)) ? CNT_MAX : 8'(erased);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cle_out_t want;
    if (!rst_n) begin
      read_pos       = '0;
      commit_pos     = '0;
      edit_pos       = '0;
      errors         = 0;
      n_results      = 0;
      n_erasures     = 0;
      n_full_commits = 0;
      n_eof_reads    = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(line_editor_result(in_data));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual %0h", $time, out_data);
        end else begin
          want = awaited_results.pop_front();
          n_results++;
          if (want.echo_kind == ECHO_ERASE) n_erasures++;
          if (want.line_ready && want.echo_char != KEY_LF && want.echo_char != KEY_CTRL_D)
            n_full_commits++;
          if (want.read_status == RD_EOF) n_eof_reads++;
          check_field("echo_kind",      8'(want.echo_kind),      8'(out_data.echo_kind));
          check_field("echo_char",      want.echo_char,          out_data.echo_char);
          check_field("erase_count",    want.erase_count,        out_data.erase_count);
          check_field("line_ready",     8'(want.line_ready),     8'(out_data.line_ready));
          check_field("show_processes", 8'(want.show_processes), 8'(out_data.show_processes));
          check_field("read_status",    8'(want.read_status),    8'(out_data.read_status));
          check_field("read_byte",      want.read_byte,          out_data.read_byte);
          check_field("eof_consumed",   8'(want.eof_consumed),   8'(out_data.eof_consumed));
        end
      end
    end
  end

endmodule

// ===== bench/tb_console_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_line_editor
// stimulus and verdict for the console line editor
// ----------------------------------------------------------------------------
// A short directed run covers the edit keys, the empty and end-of-file reads
// and the zero byte. Random typed lines, read bursts, buffer floods, long
// kills and noise follow, with random idle bursts on both channels. Checking
// is left to cle_result_checker.
// ----------------------------------------------------------------------------
module tb_console_line_editor;
  import cle_pkg::*;

  // run size and guard limits
  localparam int ITEM_TARGET = 1750;
  localparam int CALM_TAIL   = 150;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = BUF_DEPTH + 8;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  cle_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  cle_out_t out_data;

  int errors;
  int pending;
  int n_results;
  int n_erasures;
  int n_full_commits;
  int n_eof_reads;

  int items_sent;
  int idle_cycles;
  bit calm;   // set for the tail of the run: no idling on either side

  console_line_editor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  cle_result_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .errors         (errors),
    .pending        (pending),
    .n_results      (n_results),
    .n_erasures     (n_erasures),
    .n_full_commits (n_full_commits),
    .n_eof_reads    (n_eof_reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one input transaction; valid stays high between back-to-back transactions
  task automatic send_item(input cle_in_t item);
    int gap;
    if (!calm && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // a zero byte is ignored by the editor, so it does not count
    if (!(item.cmd == CMD_RX && item.rx_char == KEY_NUL)) items_sent++;
  endtask

  task automatic key_in(input logic [7:0] ch);
    cle_in_t item;
    item.cmd           = CMD_RX;
    item.rx_char       = ch;
    item.read_is_first = 1'($urandom_range(0, 1));
    send_item(item);
  endtask

  task automatic read_req(input logic first);
    cle_in_t item;
    item.cmd           = CMD_READ;
    item.rx_char       = 8'($urandom_range(0, 255));
    item.read_is_first = first;
    send_item(item);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // a read call: the first byte is flagged, later ones mostly not
  task automatic read_burst(input int n);
    for (int i = 0; i < n; i++) read_req(i == 0 || $urandom_range(0, 3) == 0);
  endtask

  // a typed line with occasional edit keys and a random terminator
  task automatic typed_line(input int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 7)       key_in(r[0] ? KEY_DEL : KEY_CTRL_H);
      else if (r < 9)  key_in(8'($urandom_range(0, 255)));
      else if (r < 10) key_in(KEY_CTRL_U);
      else if (r < 11) key_in(KEY_CTRL_P);
      else             key_in(printable());
    end
    r = $urandom_range(0, 99);
    if (r < 40)      key_in(KEY_CR);
    else if (r < 75) key_in(KEY_LF);
    else if (r < 88) key_in(KEY_CTRL_D);
  endtask

  // out_ready: random stall bursts until the tail of the run
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pick;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    calm       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty read, ignored keys, nothing to erase, process list
    read_req(1'b1);
    key_in(KEY_NUL);
    key_in(KEY_DEL);
    key_in(KEY_CTRL_U);
    key_in(KEY_CTRL_P);
    // extreme bytes, then CR commits as LF
    key_in(8'hff);
    key_in(8'h80);
    key_in(KEY_CR);
    read_req(1'b1);
    read_req(1'b0);
    read_req(1'b0);
    // end-of-file mark: left in place when not first, popped when first
    key_in(8'h78);
    key_in(KEY_CTRL_D);
    read_req(1'b1);
    read_req(1'b0);
    read_req(1'b1);
    read_req(1'b1);
    // single erase with both keys, then a kill of the rest of the line
    key_in(8'h71);
    key_in(KEY_CTRL_H);
    key_in(8'h72);
    key_in(8'h73);
    key_in(KEY_DEL);
    key_in(KEY_CTRL_U);
    key_in(KEY_LF);

    // random part: mostly well-formed typing and reading, some abuse
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent > ITEM_TARGET - CALM_TAIL);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        typed_line($urandom_range(0, 24));
        read_burst($urandom_range(0, 30));
      end else if (pick < 65) begin
        // long drain, usually runs into empty reads
        read_burst($urandom_range(20, 140));
      end else if (pick < 72) begin
        // flood: fills the ring, commits on full, then drops characters
        repeat ($urandom_range(120, 135)) key_in(printable());
        if ($urandom_range(0, 1)) key_in(KEY_CTRL_U);
      end else if (pick < 80) begin
        // long line killed in one go
        repeat ($urandom_range(20, 126)) key_in(printable());
        key_in(KEY_CTRL_U);
      end else if (pick < 88) begin
        // short line ended by Ctrl-D, read past it with and without first
        repeat ($urandom_range(0, 4)) key_in(printable());
        key_in(KEY_CTRL_D);
        read_burst($urandom_range(1, 8));
        read_req(1'b0);
        read_req(1'b1);
      end else begin
        // noise: any command, any byte, any flag
        repeat ($urandom_range(1, 10)) send_item(cle_in_t'($urandom_range(0, 1023)));
      end
    end
    in_valid <= 1'b0;

    // wait for every expected result, then let the block settle
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d results over %0d input transactions", n_results, items_sent);
    $display("saw %0d erasures, %0d full-ring commits, %0d end-of-file reads",
             n_erasures, n_full_commits, n_eof_reads);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cle_pkg.sv
rtl/core/cle_line_ram.sv
rtl/core/cle_edit_ctrl.sv
rtl/core/console_line_editor.sv
bench/cle_result_checker.sv
bench/tb_console_line_editor.sv
